// ----- rtl/indexed_list_insert_delete_search_core_assert.svh -----
// assertion macros shared by the list core
`ifndef INDEXED_LIST_INSERT_DELETE_SEARCH_CORE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_SEARCH_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define ILIST_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ilist: same-cycle check failed");

`define ILIST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ilist: next-cycle check failed");

`else

`define ILIST_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define ILIST_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/ilist_pkg.sv -----
`default_nettype none

package ilist_pkg;

   localparam int CAPACITY = 1024;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_AT    = 3'd5,
      OP_SEARCH    = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [IDX_W-1:0]  rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

// ----- rtl/ilist_mem.sv -----
`default_nettype none

module ilist_mem (
   input  wire logic                     clock,
   input  wire ilist_pkg::mem_req_type   mem_req,
   output logic [ilist_pkg::DATA_W-1:0]  rd_data
);
   import ilist_pkg::*;

   logic [DATA_W-1:0] entry_ff [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         entry_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= entry_ff[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/indexed_list_insert_delete_search_core.sv -----
`default_nettype none
// Ordered list of up to 1024 signed 32-bit values in one single-port-write,
// registered-read memory. One request is taken at a time and req_ready is low
// while it is worked on. A shared pointer and its +/-1 adder and comparator
// walk the memory one entry per cycle: an insert moves up the entries from
// its position on and then writes the value, a delete moves down the entries
// above its position, a search reads from the front until the first match or
// the count; refused requests and the unused op code go straight to the
// response. The result sits in an output register, so the work of a request
// goes on while the previous result still waits for rsp_ready; only the final
// handoff waits for it. No clearing pass is needed after reset: only entries
// below the count are ever used.
`include "indexed_list_insert_delete_search_core_assert.svh"

module indexed_list_insert_delete_search_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ilist_pkg::OP_W-1:0]    req_op,
   input  wire logic signed [ilist_pkg::DATA_W-1:0] req_value,
   input  wire logic [ilist_pkg::CNT_W-1:0]   req_position,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ilist_pkg::STATUS_W-1:0]     rsp_status,
   output logic                               rsp_found,
   output logic [ilist_pkg::IDX_W-1:0]        rsp_found_index,
   output logic [ilist_pkg::CNT_W-1:0]        rsp_item_count
);
   import ilist_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_PUT,
      S_SHIFT_DN,
      S_SEARCH,
      S_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [DATA_W-1:0]  value_ff, value_in;
   status_type         status_ff, status_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   fidx_ff, fidx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]    rsp_fidx_ff, rsp_fidx_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   mem_req_type         mem_req;
   logic [DATA_W-1:0]   rd_data;
   logic                req_xfer;

   ilist_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      logic [CNT_W-1:0] pos_sel;
      logic [IDX_W-1:0] ptr_dn;
      logic [IDX_W-1:0] ptr_up;

      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      fidx_in       = fidx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_fidx_in   = rsp_fidx_ff;
      rsp_count_in  = rsp_count_ff;

      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = ptr_ff;
      mem_req.wr_data = rd_data;
      mem_req.rd_addr = ptr_ff;

      // shared pointer step
      ptr_dn = ptr_ff - IDX_W'(1);
      ptr_up = ptr_ff + IDX_W'(1);

      pos_sel = '0;
      case (op_type'(req_op))
         OP_INS_BACK: pos_sel = count_ff;
         OP_INS_AT:   pos_sel = req_position;
         OP_DEL_BACK: pos_sel = count_ff - CNT_W'(1);
         OP_DEL_AT:   pos_sel = req_position;
         default:     pos_sel = '0;
      endcase

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               status_in = ST_DONE;
               found_in  = 1'b0;
               fidx_in   = '0;
               value_in  = req_value;
               pos_in    = pos_sel[IDX_W-1:0];
               state_in  = S_RESP;
               case (op_type'(req_op)) inside
                  OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else if (pos_sel > count_ff) begin
                        status_in = ST_RANGE;
                     end else begin
                        ptr_in          = count_ff[IDX_W-1:0];
                        mem_req.rd_addr = count_ff[IDX_W-1:0] - IDX_W'(1);
                        state_in        = (pos_sel == count_ff) ? S_PUT : S_SHIFT_UP;
                     end
                  end
                  OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (pos_sel >= count_ff) begin
                        status_in = ST_RANGE;
                     end else begin
                        ptr_in          = pos_sel[IDX_W-1:0];
                        mem_req.rd_addr = pos_sel[IDX_W-1:0] + IDX_W'(1);
                        if (pos_sel + CNT_W'(1) == count_ff) begin
                           // last entry goes, nothing to move
                           count_in = count_ff - CNT_W'(1);
                        end else begin
                           state_in = S_SHIFT_DN;
                        end
                     end
                  end
                  OP_SEARCH: begin
                     ptr_in          = '0;
                     mem_req.rd_addr = '0;
                     if (count_ff != '0) begin
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SHIFT_UP: begin
            // entry ptr-1 arrives, moves up to ptr
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ptr_ff;
            mem_req.wr_data = rd_data;
            mem_req.rd_addr = ptr_ff - IDX_W'(2);
            ptr_in          = ptr_dn;
            if (ptr_dn == pos_ff) begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            mem_req.wr_data = value_ff;
            count_in        = count_ff + CNT_W'(1);
            state_in        = S_RESP;
         end
         S_SHIFT_DN: begin
            // entry ptr+1 arrives, moves down to ptr
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ptr_ff;
            mem_req.wr_data = rd_data;
            mem_req.rd_addr = ptr_ff + IDX_W'(2);
            ptr_in          = ptr_up;
            if (CNT_W'(ptr_ff) + CNT_W'(2) == count_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESP;
            end
         end
         S_SEARCH: begin
            mem_req.rd_addr = ptr_up;
            ptr_in          = ptr_up;
            if (rd_data == value_ff) begin
               found_in = 1'b1;
               fidx_in  = ptr_ff;
               state_in = S_RESP;
            end else if (CNT_W'(ptr_ff) + CNT_W'(1) == count_ff) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_fidx_in   = fidx_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      fidx_ff       <= fidx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_fidx_ff   <= rsp_fidx_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_fidx_ff;
   assign rsp_item_count  = rsp_count_ff;

   `ILIST_ASSERT_IMP(a_count_cap, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `ILIST_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, !req_ready)
   `ILIST_ASSERT_IMP(a_found_in_list, clock, reset, rsp_valid && rsp_found,
      CNT_W'(rsp_found_index) < rsp_item_count)
   `ILIST_ASSERT_NEXT(a_idle_count_hold, clock, reset, (state_ff == S_IDLE) && !req_xfer,
      count_ff == $past(count_ff))
   `ILIST_ASSERT_IMP(a_write_when_moving, clock, reset, mem_req.wr_en,
      (state_ff == S_SHIFT_UP) || (state_ff == S_PUT) || (state_ff == S_SHIFT_DN))

endmodule

`default_nettype wire

// ----- test/indexed_list_insert_delete_search_core_tb.sv -----
`timescale 1ns / 1ps

module indexed_list_insert_delete_search_core_tb;
   import ilist_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
   localparam int DRAIN_CYCLES = CAPACITY + 80;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [IDX_W-1:0]    found_index;
      logic [CNT_W-1:0]    item_count;
   } list_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [OP_W-1:0] req_op = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic [CNT_W-1:0] req_position = '0;
   logic rsp_ready = 1'b0;
   wire req_ready;
   wire rsp_valid;
   wire [STATUS_W-1:0] rsp_status;
   wire rsp_found;
   wire [IDX_W-1:0] rsp_found_index;
   wire [CNT_W-1:0] rsp_item_count;

   // mirror of the list contents and the replies still owed by the block
   logic signed [DATA_W-1:0] shadow_entries[$];
   list_reply_type owed_replies[$];
   int mismatch_count = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int rsp_hold_cycles = 0;

   indexed_list_insert_delete_search_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_found(rsp_found),
      .rsp_found_index(rsp_found_index),
      .rsp_item_count(rsp_item_count)
   );

   always #4 clock = ~clock;

   function automatic int idle_length(bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // applies one operation to the mirror list and returns the reply it earns
   function automatic list_reply_type apply_list_op(logic [OP_W-1:0] op,
                                                    logic signed [DATA_W-1:0] value,
                                                    logic [CNT_W-1:0] position);
      list_reply_type r;
      int count;
      int idx;
      int i;
      r = '0;
      r.status = ST_DONE;
      count = shadow_entries.size();
      case (op)
         OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
            idx = (op == OP_INS_FRONT) ? 0 : (op == OP_INS_BACK) ? count : int'(position);
            if (count >= CAPACITY) r.status = ST_FULL;
            else if (idx > count) r.status = ST_RANGE;
            else shadow_entries.insert(idx, value);
         end
         OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
            idx = (op == OP_DEL_FRONT) ? 0 : (op == OP_DEL_BACK) ? count - 1 : int'(position);
            if (count == 0) r.status = ST_EMPTY;
            else if (idx >= count) r.status = ST_RANGE;
            else shadow_entries.delete(idx);
         end
         OP_SEARCH: begin
            for (i = 0; i < count && !r.found; i++) begin
               if (shadow_entries[i] == value) begin
                  r.found = 1'b1;
                  r.found_index = IDX_W'(i);
               end
            end
         end
         default: ;
      endcase
      r.item_count = CNT_W'(shadow_entries.size());
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2, 3, 4: return DATA_W'($signed($urandom_range(0, 6)) - 3);
         default: return $urandom;
      endcase
   endfunction

   task automatic push_list_request(input logic [OP_W-1:0] op,
                                    input logic signed [DATA_W-1:0] value,
                                    input logic [CNT_W-1:0] position);
      int gap;
      gap = idle_length(req_idle_on);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_value <= value;
      req_position <= position;
      do @(posedge clock); while (!req_ready);
      owed_replies.push_back(apply_list_op(op, value, position));
   endtask

   task automatic send_random_op(input int target_size);
      int count;
      int pick;
      bit grow;
      logic [OP_W-1:0] op;
      logic signed [DATA_W-1:0] value;
      logic [CNT_W-1:0] position;
      count = shadow_entries.size();
      pick = $urandom_range(0, 99);
      grow = (count < target_size) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) < 3);
      if (pick < 3) op = OP_UNUSED;
      else if (pick < 20) op = OP_SEARCH;
      else if (grow) op = OP_W'($urandom_range(0, 2));
      else op = OP_W'(3 + $urandom_range(0, 2));
      value = pick_value();
      if (op == OP_SEARCH && count > 0 && $urandom_range(0, 1) == 1)
         value = shadow_entries[$urandom_range(0, count - 1)];
      if ($urandom_range(0, 9) == 0 || op == OP_SEARCH || op == OP_UNUSED)
         position = CNT_W'($urandom_range(0, CAPACITY));
      else if (op == OP_INS_FRONT || op == OP_INS_BACK || op == OP_INS_AT)
         position = CNT_W'($urandom_range(0, count));
      else
         position = (count == 0) ? '0 : CNT_W'($urandom_range(0, count - 1));
      push_list_request(op, value, position);
   endtask

   task automatic test_empty_list();
      push_list_request(OP_DEL_FRONT, 32'sd1, 11'd0);
      push_list_request(OP_DEL_BACK, 32'sd1, 11'd0);
      push_list_request(OP_DEL_AT, 32'sd1, 11'd0);
      push_list_request(OP_SEARCH, 32'sd0, 11'd0);
      push_list_request(OP_UNUSED, -32'sd1, CNT_W'(CAPACITY));
      push_list_request(OP_INS_AT, 32'sd9, 11'd1);
      push_list_request(OP_INS_AT, 32'sd9, CNT_W'(CAPACITY));
   endtask

   task automatic test_insert_variants();
      push_list_request(OP_INS_FRONT, 32'sh7fff_ffff, 11'd0);
      push_list_request(OP_INS_BACK, 32'sh8000_0000, 11'd0);
      push_list_request(OP_INS_AT, -32'sd1, 11'd1);
      // position equal to the count appends
      push_list_request(OP_INS_AT, 32'sd0, 11'd3);
      push_list_request(OP_INS_FRONT, -32'sd1, 11'd0);
      push_list_request(OP_INS_AT, 32'sd5, 11'd7);
   endtask

   task automatic test_search();
      push_list_request(OP_SEARCH, -32'sd1, 11'd0);
      push_list_request(OP_SEARCH, 32'sd0, 11'd0);
      push_list_request(OP_SEARCH, 32'sh8000_0000, 11'd0);
      push_list_request(OP_SEARCH, 32'sd5, 11'd0);
      push_list_request(OP_UNUSED, 32'sd0, 11'd2);
   endtask

   task automatic test_delete_variants();
      push_list_request(OP_DEL_AT, 32'sd0, 11'd5);
      push_list_request(OP_DEL_AT, 32'sd0, CNT_W'(CAPACITY));
      push_list_request(OP_DEL_AT, 32'sd0, 11'd2);
      push_list_request(OP_DEL_FRONT, 32'sd0, 11'd0);
      push_list_request(OP_DEL_BACK, 32'sd0, 11'd0);
      push_list_request(OP_DEL_BACK, 32'sd0, 11'd0);
      // removing the only entry leaves the list empty
      push_list_request(OP_DEL_AT, 32'sd0, 11'd0);
      push_list_request(OP_DEL_BACK, 32'sd0, 11'd0);
   endtask

   task automatic test_random_mix(input int chunks);
      int c;
      int k;
      int target_size;
      for (c = 0; c < chunks; c++) begin
         target_size = (c % 3 == 2) ? 0 : $urandom_range(4, 48);
         req_idle_on = (c % 4 != 1);
         rsp_idle_on = (c % 4 != 3);
         for (k = 0; k < 50; k++) send_random_op(target_size);
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // receiver stalls for a long time while requests keep coming back to back
   task automatic test_backpressure();
      int k;
      req_idle_on = 1'b0;
      rsp_hold_cycles = 400;
      for (k = 0; k < 10; k++) send_random_op(12);
      req_idle_on = 1'b1;
   endtask

   // response side: random stalls, plus a long hold when one is requested
   initial begin
      int stall;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (rsp_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else begin
            stall = idle_length(rsp_idle_on);
            if (stall == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (stall - 1) @(posedge clock);
            end
         end
      end
   end

   // compare every response transfer with the oldest owed reply
   always @(posedge clock) begin
      list_reply_type want;
      list_reply_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_status, rsp_found, rsp_found_index, rsp_item_count};
         if (owed_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected reply: status %0d found %0d index %0d count %0d",
                        got.status, got.found, got.found_index, got.item_count);
         end else begin
            want = owed_replies.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("reply mismatch: exp status %0d found %0d index %0d count %0d, %s",
                           want.status, want.found, want.found_index, want.item_count,
                           $sformatf("got status %0d found %0d index %0d count %0d",
                                     got.status, got.found, got.found_index,
                                     got.item_count));
            end
         end
      end
   end

   initial begin
      #100_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_insert_variants();
      test_search();
      test_delete_variants();
      test_random_mix(4);
      test_backpressure();
      test_random_mix(4);
      req_valid <= 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && owed_replies.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
